// File: rtl/mt32_pkg.sv
// ============================================================================
// mt32_pkg
// Shared types, constants and word functions of the 32-bit twister generator.
// ============================================================================
package mt32_pkg;

    localparam int WORD_W           = 32;
    localparam int STATE_WORDS_DEF  = 624;
    localparam int SHIFT_OFFSET_DEF = 397;

    localparam logic [WORD_W-1:0] INIT_MULT = 32'd1812433253;
    localparam logic [WORD_W-1:0] TWIST_XOR = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C  = 32'hefc6_0000;

    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    typedef enum logic [1:0] {
        SEED_IDLE = 2'b01,
        SEED_RUN  = 2'b10
    } t_seed_state;

    typedef struct packed {
        logic              busy;
        logic              shift;
        logic [WORD_W-1:0] word;
    } t_seed_ctl;

    function automatic logic [WORD_W-1:0] twist_word(
        input logic [WORD_W-1:0] w_cur,
        input logic [WORD_W-1:0] w_nxt,
        input logic [WORD_W-1:0] w_far
    );
        logic [WORD_W-1:0] joined;
        logic [WORD_W-1:0] fold;
        joined = {w_cur[WORD_W-1], w_nxt[WORD_W-2:0]};
        fold   = joined[0] ? TWIST_XOR : '0;
        return w_far ^ (joined >> 1) ^ fold;
    endfunction

    function automatic logic [WORD_W-1:0] temper_word(input logic [WORD_W-1:0] w_in);
        logic [WORD_W-1:0] y;
        y = w_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// File: rtl/mt32_cell.sv
// ============================================================================
// mt32_cell
// One state word of the twister ring; takes its right neighbor's word on shift.
// ============================================================================
module mt32_cell (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic [mt32_pkg::WORD_W-1:0] i_word,
    output logic [mt32_pkg::WORD_W-1:0] o_word
);
    import mt32_pkg::*;

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        n_word = i_shift ? i_word : r_word;
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// File: rtl/mt32_seed.sv
// ============================================================================
// mt32_seed
// Seed loader: produces one initializer word per cycle for the cell ring.
// ============================================================================
module mt32_seed #(
    parameter int STATE_WORDS = mt32_pkg::STATE_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mt32_pkg::WORD_W-1:0] i_seed,
    input  logic [mt32_pkg::WORD_W-1:0] i_prev,
    output mt32_pkg::t_seed_ctl         o_ctl
);
    import mt32_pkg::*;

    localparam int CNT_W = $clog2(STATE_WORDS);

    t_seed_state       r_state;
    t_seed_state       n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] n_seed;
    logic [WORD_W-1:0] mixed;
    logic [WORD_W-1:0] product;
    logic [WORD_W-1:0] init_word;

    always_comb begin
        mixed     = i_prev ^ (i_prev >> 30);
        product   = mixed * INIT_MULT;
        init_word = (r_cnt == '0) ? r_seed : product + WORD_W'(r_cnt);
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_seed  = r_seed;
        case (r_state)
            SEED_IDLE: begin
                if (i_start) begin
                    n_state = SEED_RUN;
                    n_cnt   = '0;
                    n_seed  = i_seed;
                end
            end
            SEED_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STATE_WORDS - 1)) begin
                    n_state = SEED_IDLE;
                    n_cnt   = '0;
                end
            end
            default: begin
                n_state = SEED_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEED_RUN;
            r_cnt   <= '0;
            r_seed  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_seed  <= n_seed;
        end
    end

    always_comb begin
        o_ctl.busy  = (r_state == SEED_RUN);
        o_ctl.shift = (r_state == SEED_RUN);
        o_ctl.word  = init_word;
    end

endmodule

// File: rtl/mt19937_32bit_generator.sv
// ============================================================================
// mt19937_32bit_generator
// MT19937 generator built as a ring of word cells regenerated one word per draw.
// ============================================================================
// Input channel: i_valid / o_stall with i_opcode and i_seed_value. A draw
// request (opcode 0) yields one tempered word; a reseed request (opcode 1)
// yields nothing. Output channel: o_valid / i_stall with o_random_word.
// A draw's word is registered at the accepting edge, in the output register
// if it is free or being taken, else in the skid entry. Draws sustain one per
// cycle while o_stall is low; each twists the word at the head of a 624-cell
// ring and shifts the ring. A reseed holds o_stall high while the seed loader
// feeds one initializer word per cycle into the ring, those after the seed set
// by its one multiply. After reset the same loader runs with seed zero, so
// o_stall stays high until the ring is loaded. The output side has a two-entry
// buffer: when the receiver stalls, one more draw is still taken, then o_stall
// rises until the buffered word moves on. Pending words are kept across reseeds.
// ============================================================================
module mt19937_32bit_generator #(
    parameter int STATE_WORDS  = mt32_pkg::STATE_WORDS_DEF,
    parameter int SHIFT_OFFSET = mt32_pkg::SHIFT_OFFSET_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_opcode,
    input  logic [mt32_pkg::WORD_W-1:0] i_seed_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [mt32_pkg::WORD_W-1:0] o_random_word
);
    import mt32_pkg::*;

    t_seed_ctl         seed_ctl;
    logic [WORD_W-1:0] ring [STATE_WORDS];
    logic [WORD_W-1:0] feed_word;
    logic [WORD_W-1:0] new_word;
    logic [WORD_W-1:0] out_word;
    logic              in_acc;
    logic              draw_acc;
    logic              seed_start;
    logic              ring_shift;
    logic              take;

    logic              r_out_valid;
    logic              n_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic [WORD_W-1:0] n_out_word;
    logic              r_skid_valid;
    logic              n_skid_valid;
    logic [WORD_W-1:0] r_skid_word;
    logic [WORD_W-1:0] n_skid_word;

    assign o_stall    = seed_ctl.busy || r_skid_valid;
    assign in_acc     = i_valid && !o_stall;
    assign draw_acc   = in_acc && (i_opcode == OP_DRAW);
    assign seed_start = in_acc && (i_opcode == OP_RESEED);
    assign ring_shift = seed_ctl.shift || draw_acc;
    assign take       = r_out_valid && !i_stall;

    mt32_seed #(
        .STATE_WORDS(STATE_WORDS)
    ) u_seed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (seed_start),
        .i_seed  (i_seed_value),
        .i_prev  (ring[STATE_WORDS-1]),
        .o_ctl   (seed_ctl)
    );

    always_comb begin
        new_word  = twist_word(ring[0], ring[1], ring[SHIFT_OFFSET]);
        out_word  = temper_word(new_word);
        feed_word = seed_ctl.busy ? seed_ctl.word : new_word;
    end

    genvar g;
    generate
        for (g = 0; g < STATE_WORDS; g++) begin : g_cell
            if (g == STATE_WORDS - 1) begin : g_tail
                mt32_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (ring_shift),
                    .i_word  (feed_word),
                    .o_word  (ring[g])
                );
            end else begin : g_body
                mt32_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (ring_shift),
                    .i_word  (ring[g+1]),
                    .o_word  (ring[g])
                );
            end
        end
    endgenerate

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;
        n_skid_valid = r_skid_valid;
        n_skid_word  = r_skid_word;
        if (!r_out_valid || take) begin
            n_out_valid  = r_skid_valid || draw_acc;
            n_out_word   = r_skid_valid ? r_skid_word : out_word;
            n_skid_valid = 1'b0;
        end else if (draw_acc) begin
            n_skid_valid = 1'b1;
            n_skid_word  = out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word  <= n_out_word;
        r_skid_word <= n_skid_word;
    end

    assign o_valid       = r_out_valid;
    assign o_random_word = r_out_word;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_draw_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        draw_acc |=> r_out_valid)
        else $error("accepted draw left no word");

    a_reseed_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seed_start |=> (o_stall && seed_ctl.busy))
        else $error("reseed request did not start the seed loader");

    a_no_mixed_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seed_ctl.shift |-> !draw_acc)
        else $error("draw accepted while ring is being seeded");

endmodule

// File: tb/mt19937_32bit_generator_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// mt19937_32bit_generator_tb
// Self-checking bench for the MT19937 generator: draw and reseed requests are
// run through a local copy of the twister state, and every word that comes
// out is compared in order with the one predicted for it.
// ============================================================================
module mt19937_32bit_generator_tb;

    import mt32_pkg::*;

    localparam int NWORDS     = STATE_WORDS_DEF;
    localparam int FAR_OFFSET = SHIFT_OFFSET_DEF;
    localparam int RAND_REQS  = 1550;
    localparam int CYCLE_CAP  = 2000000;
    localparam int DRAIN_WAIT = 700;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        logic              op;
        logic [WORD_W-1:0] seed;
    } t_request;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              i_opcode     = OP_DRAW;
    logic [WORD_W-1:0] i_seed_value = '0;
    logic              i_stall      = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [WORD_W-1:0] o_random_word;

    t_request          pending_reqs [$];
    logic [WORD_W-1:0] expected_words [$];

    logic [WORD_W-1:0] twister_mem [0:NWORDS-1];
    int unsigned       twister_pos;

    int  errors       = 0;
    int  n_accepted   = 0;
    int  n_draws      = 0;
    int  n_reseeds    = 0;
    int  n_regens     = 0;
    int  n_checked    = 0;
    int  cycles       = 0;
    int  hold_cnt     = 0;
    bit  hold_done    = 1'b0;
    bit  calm;

    mt19937_32bit_generator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_seed_value  (i_seed_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_random_word (o_random_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    assign calm = (n_accepted >= 700) && (n_accepted < 1000);

    function automatic void twister_load(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] prev;
        twister_mem[0] = seed;
        for (int k = 1; k < NWORDS; k++) begin
            prev           = twister_mem[k-1];
            twister_mem[k] = INIT_MULT * (prev ^ (prev >> 30)) + WORD_W'(k);
        end
        twister_pos = NWORDS;
    endfunction

    function automatic void twister_regen();
        logic [WORD_W-1:0] joined;
        for (int k = 0; k < NWORDS; k++) begin
            joined = (twister_mem[k] & 32'h8000_0000)
                   | (twister_mem[(k + 1) % NWORDS] & 32'h7fff_ffff);
            twister_mem[k] = twister_mem[(k + FAR_OFFSET) % NWORDS] ^ (joined >> 1)
                           ^ (joined[0] ? TWIST_XOR : 32'h0);
        end
        twister_pos = 0;
    endfunction

    function automatic logic [WORD_W-1:0] tempered(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        return y ^ (y >> 18);
    endfunction

    // advance the local twister by one request and queue the word it yields
    task automatic twister_apply(input logic op, input logic [WORD_W-1:0] seed);
        if (op == OP_RESEED) begin
            twister_load(seed);
            n_reseeds++;
        end else begin
            if (twister_pos >= NWORDS) begin
                twister_regen();
                n_regens++;
            end
            expected_words.push_back(tempered(twister_mem[twister_pos]));
            twister_pos++;
            n_draws++;
        end
    endtask

    task automatic report(input string what, input logic [WORD_W-1:0] got,
                          input logic [WORD_W-1:0] want);
        errors++;
        $display("MISMATCH @%0d word %0d: %s got %08h want %08h",
                 cycles, n_checked, what, got, want);
    endtask

    task automatic push_req(input logic op, input logic [WORD_W-1:0] seed);
        t_request r;
        r.op   = op;
        r.seed = seed;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [WORD_W-1:0] pick_seed();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 32'd5489;
            default: return $urandom;
        endcase
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_request r;
        bit       took;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            took = i_valid && !o_stall;
            if (took) begin
                twister_apply(i_opcode, i_seed_value);
                n_accepted++;
            end
            if (!i_valid || took) begin
                if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
                    r = pending_reqs.pop_front();
                    i_valid      <= 1'b1;
                    i_opcode     <= r.op;
                    i_seed_value <= r.seed;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            i_stall <= 1'b1;
        end else if (!hold_done && n_accepted >= 300) begin
            hold_done = 1'b1;
            hold_cnt  = HOLD_LEN;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 9);
        end
    end

    // output word check
    always @(posedge i_clk) begin
        logic [WORD_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                report("unexpected word", o_random_word, '0);
            end else begin
                want = expected_words.pop_front();
                if (o_random_word !== want)
                    report("random_word", o_random_word, want);
            end
            n_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("mt19937_32bit_generator test failed");
            $finish;
        end
    end

    initial begin
        int total;
        int n;
        twister_load('0);

        // draws from the reset state, seed field ignored on draw
        push_req(OP_DRAW, '0);
        push_req(OP_DRAW, '1);
        push_req(OP_DRAW, 32'h5555_5555);
        push_req(OP_DRAW, 32'haaaa_aaaa);
        // seed extremes and the usual default seed
        push_req(OP_RESEED, 32'd5489);
        push_req(OP_DRAW, '0);
        push_req(OP_DRAW, '0);
        push_req(OP_RESEED, '1);
        push_req(OP_DRAW, 32'h1234_5678);
        push_req(OP_DRAW, '1);
        push_req(OP_RESEED, '0);
        push_req(OP_DRAW, '0);
        push_req(OP_DRAW, '0);
        // back-to-back reseeds, the last one counts
        push_req(OP_RESEED, 32'hdead_beef);
        push_req(OP_RESEED, 32'h0000_0001);
        push_req(OP_DRAW, '0);
        push_req(OP_RESEED, 32'h8000_0000);
        push_req(OP_RESEED, 32'h7fff_ffff);
        push_req(OP_RESEED, 32'hffff_fffe);
        push_req(OP_DRAW, '1);
        push_req(OP_DRAW, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender pause: wait until every expected word is back
        while (pending_reqs.size() != 0 || i_valid || expected_words.size() != 0)
            @(posedge i_clk);

        // random part: seed segments followed by runs of draws, some long
        // enough to run past a full regeneration
        total = 0;
        while (total < RAND_REQS) begin
            if (total == 0 || $urandom_range(9) < 7) begin
                if ($urandom_range(9) == 0) begin
                    push_req(OP_RESEED, $urandom);
                    total++;
                end
                push_req(OP_RESEED, pick_seed());
                total++;
            end
            if (total <= 2 || $urandom_range(3) == 0)
                n = $urandom_range(625, 800);
            else
                n = $urandom_range(1, 60);
            if (n > RAND_REQS - total)
                n = RAND_REQS - total;
            repeat (n) begin
                push_req(OP_DRAW, $urandom);
                total++;
            end
        end

        while (pending_reqs.size() != 0 || i_valid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d requests: %0d draws, %0d reseeds, %0d regenerations",
                 n_accepted, n_draws, n_reseeds, n_regens);
        $display("%0d words checked, %0d mismatches, %0d cycles", n_checked, errors, cycles);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("mt19937_32bit_generator test passed");
        end else begin
            $display("mt19937_32bit_generator test failed");
        end
        $finish;
    end

endmodule

// File: mt19937_32bit_generator.f
rtl/mt32_pkg.sv
rtl/mt32_cell.sv
rtl/mt32_seed.sv
rtl/mt19937_32bit_generator.sv
tb/mt19937_32bit_generator_tb.sv
